>>> sv/mpr_pkg.sv
// shared types and constants of the progenitor merit ranker
package mpr_pkg;

    localparam int MAX_PROGENITORS = 64;
    localparam int IDX_W = $clog2(MAX_PROGENITORS);
    localparam int CNT_W = IDX_W + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    // divisor width of the shared divider (Q16.16 denominator fits in 50 bits)
    localparam int DEN_W = 50;
    // 1.01 in Q16.16
    localparam logic [16:0] SCALE_101 = 17'd66191;
    localparam logic [DEN_W-1:0] Q16_ONE = DEN_W'(65536);

    typedef struct packed {
        logic [63:0] progenitor_id;
        logic [31:0] shared_count;
        logic [31:0] progenitor_particles;
        logic [31:0] main_particles;
        logic        last_in;
    } t_in_word;

    typedef struct packed {
        logic [63:0]      ranked_id;
        logic [31:0]      ranked_shared;
        logic [IDX_W-1:0] original_position;
        logic             orphan;
        logic             dropped;
        logic             last_out;
    } t_out_word;

    // classified candidate passed from front to back
    typedef struct packed {
        logic [63:0] id;
        logic [31:0] shared;
        logic [31:0] hi;
        logic [31:0] lo;
        logic        keep;
        logic        last;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_chan;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLASS,
        ST_RATIO,
        ST_MUL,
        ST_DENOM,
        ST_MERIT,
        ST_STORE,
        ST_CHECK,
        ST_SCAN,
        ST_FETCH,
        ST_EMIT,
        ST_ORPHAN
    } t_state;

endpackage

>>> sv/mpr_front.sv
// front end: config register, candidate classification and job queue
module mpr_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [31:0]         i_cfg_data,
    input  logic                push,
    output logic                full,
    input  mpr_pkg::t_in_word   i_in_word,
    output mpr_pkg::t_job_chan  o_job,
    input  logic                i_job_pop
);

    logic [31:0]                 r_min_shared;
    mpr_pkg::t_job               r_queue [mpr_pkg::QUEUE_DEPTH];
    logic [mpr_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [mpr_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [mpr_pkg::QPTR_W:0]    r_count;
    mpr_pkg::t_job               job_in;
    logic                        wr_en;
    logic                        rd_en;
    logic [31:0]                 prog_fix;
    logic [31:0]                 main_fix;

    assign o_cfg_ready = 1'b1;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_shared <= '0;
        end else if (i_cfg_valid) begin
            r_min_shared <= i_cfg_data;
        end
    end

    // zero counts treated as one, order the pair, threshold test
    always_comb begin
        prog_fix = (i_in_word.progenitor_particles == '0) ? 32'd1
                                                          : i_in_word.progenitor_particles;
        main_fix = (i_in_word.main_particles == '0) ? 32'd1 : i_in_word.main_particles;
        job_in.id     = i_in_word.progenitor_id;
        job_in.shared = i_in_word.shared_count;
        job_in.hi     = (prog_fix > main_fix) ? prog_fix : main_fix;
        job_in.lo     = (prog_fix > main_fix) ? main_fix : prog_fix;
        job_in.keep   = i_in_word.shared_count > r_min_shared;
        job_in.last   = i_in_word.last_in;
    end

    assign full  = (r_count == (mpr_pkg::QPTR_W+1)'(mpr_pkg::QUEUE_DEPTH));
    assign wr_en = push && !full;
    assign rd_en = i_job_pop && (r_count != '0);

    // job queue storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_queue[r_wr_ptr] <= job_in;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_job.valid = (r_count != '0);
    assign o_job.job   = r_queue[r_rd_ptr];

endmodule

>>> sv/mpr_div.sv
// radix-2 restoring divider, 64-bit dividend, one quotient bit per cycle
module mpr_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [63:0]               i_dividend,
    input  logic [mpr_pkg::DEN_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [63:0]               o_quotient
);

    logic [mpr_pkg::DEN_W-1:0] r_rem;
    logic [mpr_pkg::DEN_W-1:0] r_div;
    logic [63:0]               r_quo;
    logic [5:0]                r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic [mpr_pkg::DEN_W:0]   trial;
    logic                      ge;
    logic [mpr_pkg::DEN_W-1:0] n_rem;
    logic [63:0]               n_quo;

    // one shift-subtract step
    always_comb begin
        trial = {r_rem, r_quo[63]};
        ge    = trial >= {1'b0, r_div};
        n_rem = ge ? mpr_pkg::DEN_W'(trial - {1'b0, r_div})
                   : trial[mpr_pkg::DEN_W-1:0];
        n_quo = {r_quo[62:0], ge};
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> sv/mpr_back.sv
// back end: merit computation, candidate store, ranking and result queue
module mpr_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mpr_pkg::t_job_chan  i_job,
    output logic                o_job_pop,
    output logic                empty,
    input  logic                pop,
    output mpr_pkg::t_out_word  o_out_word
);

    localparam int IW = mpr_pkg::IDX_W;
    localparam int CW = mpr_pkg::CNT_W;
    localparam int DW = mpr_pkg::DEN_W;

    mpr_pkg::t_state  r_state;
    mpr_pkg::t_state  n_state;
    mpr_pkg::t_job    r_job;

    // candidate stores
    logic [63:0] id_mem     [mpr_pkg::MAX_PROGENITORS];
    logic [31:0] shared_mem [mpr_pkg::MAX_PROGENITORS];
    logic [63:0] merit_mem  [mpr_pkg::MAX_PROGENITORS];

    logic [CW-1:0]    r_kept;
    logic             r_ovf;
    logic [mpr_pkg::MAX_PROGENITORS-1:0] r_used;
    logic [CW-1:0]    r_rank_cnt;
    logic [CW-1:0]    r_scan;
    logic             r_rd_v;
    logic [IW-1:0]    r_rd_idx;
    logic [63:0]      r_merit_q;
    logic             r_best_v;
    logic [IW-1:0]    r_best_idx;
    logic [63:0]      r_best_merit;
    logic [63:0]      r_id_q;
    logic [31:0]      r_sh_q;
    logic [48:0]      r_p_hi;
    logic [32:0]      r_p_lo;

    // result queue
    mpr_pkg::t_out_word r_oq [2];
    logic               r_oq_wr;
    logic               r_oq_rd;
    logic [1:0]         r_oq_cnt;

    // control
    logic             div_start;
    logic [63:0]      div_dividend;
    logic [DW-1:0]    div_divisor;
    logic             div_done;
    logic [63:0]      div_quo;
    logic             oq_space;
    logic             oq_push;
    logic             oq_pop;
    mpr_pkg::t_out_word oq_word;
    logic             take_best;
    logic             can_store;
    logic             scan_end;
    logic             emit_last;
    logic [DW-1:0]    scaled;
    logic [DW-1:0]    denom;

    mpr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign can_store = !r_kept[CW-1];
    assign oq_space  = (r_oq_cnt != 2'd2);
    assign scan_end  = (r_scan == r_kept) && !r_rd_v;
    assign emit_last = (r_rank_cnt == r_kept - 1'b1);
    assign take_best = r_rd_v && !r_used[r_rd_idx] &&
                       (!r_best_v || (r_merit_q >= r_best_merit));

    // 1.01 * ratio - 1 in Q16.16
    always_comb begin
        scaled = DW'(r_p_hi) + DW'(r_p_lo[32:16]);
        denom  = scaled - mpr_pkg::Q16_ONE;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mpr_pkg::ST_IDLE:   if (i_job.valid) n_state = mpr_pkg::ST_CLASS;
            mpr_pkg::ST_CLASS: begin
                if (r_job.keep && can_store) begin
                    n_state = mpr_pkg::ST_RATIO;
                end else begin
                    n_state = mpr_pkg::ST_CHECK;
                end
            end
            mpr_pkg::ST_RATIO:  if (div_done) n_state = mpr_pkg::ST_MUL;
            mpr_pkg::ST_MUL:    n_state = mpr_pkg::ST_DENOM;
            mpr_pkg::ST_DENOM:  n_state = mpr_pkg::ST_MERIT;
            mpr_pkg::ST_MERIT:  if (div_done) n_state = mpr_pkg::ST_STORE;
            mpr_pkg::ST_STORE:  n_state = mpr_pkg::ST_CHECK;
            mpr_pkg::ST_CHECK: begin
                if (!r_job.last) begin
                    n_state = mpr_pkg::ST_IDLE;
                end else if (r_kept == '0) begin
                    n_state = mpr_pkg::ST_ORPHAN;
                end else begin
                    n_state = mpr_pkg::ST_SCAN;
                end
            end
            mpr_pkg::ST_SCAN:   if (scan_end) n_state = mpr_pkg::ST_FETCH;
            mpr_pkg::ST_FETCH:  n_state = mpr_pkg::ST_EMIT;
            mpr_pkg::ST_EMIT: begin
                if (oq_space) begin
                    n_state = emit_last ? mpr_pkg::ST_IDLE : mpr_pkg::ST_SCAN;
                end
            end
            mpr_pkg::ST_ORPHAN: if (oq_space) n_state = mpr_pkg::ST_IDLE;
            default:            n_state = mpr_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_job_pop    = 1'b0;
        div_start    = 1'b0;
        div_dividend = {16'b0, r_job.hi, 16'b0};
        div_divisor  = DW'(r_job.lo);
        oq_push      = 1'b0;
        oq_word      = '0;
        case (r_state)
            mpr_pkg::ST_IDLE:  o_job_pop = i_job.valid;
            mpr_pkg::ST_CLASS: div_start = r_job.keep && can_store;
            mpr_pkg::ST_DENOM: begin
                div_start    = 1'b1;
                div_dividend = {r_job.shared, 32'b0};
                div_divisor  = denom;
            end
            mpr_pkg::ST_EMIT: begin
                oq_push                   = oq_space;
                oq_word.ranked_id         = r_id_q;
                oq_word.ranked_shared     = r_sh_q;
                oq_word.original_position = r_best_idx;
                oq_word.dropped           = r_ovf;
                oq_word.last_out          = emit_last;
            end
            mpr_pkg::ST_ORPHAN: begin
                oq_push          = oq_space;
                oq_word.orphan   = 1'b1;
                oq_word.dropped  = r_ovf;
                oq_word.last_out = 1'b1;
            end
            default: begin
                o_job_pop = 1'b0;
            end
        endcase
    end

    // state and set bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mpr_pkg::ST_IDLE;
            r_kept     <= '0;
            r_ovf      <= 1'b0;
            r_used     <= '0;
            r_rank_cnt <= '0;
            r_scan     <= '0;
            r_rd_v     <= 1'b0;
            r_best_v   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= 1'b0;
            case (r_state)
                mpr_pkg::ST_CLASS: begin
                    if (r_job.keep && !can_store) begin
                        r_ovf <= 1'b1;
                    end
                end
                mpr_pkg::ST_STORE: r_kept <= r_kept + 1'b1;
                mpr_pkg::ST_CHECK: begin
                    r_used     <= '0;
                    r_rank_cnt <= '0;
                    r_scan     <= '0;
                    r_best_v   <= 1'b0;
                end
                mpr_pkg::ST_SCAN: begin
                    if (r_scan != r_kept) begin
                        r_scan <= r_scan + 1'b1;
                        r_rd_v <= 1'b1;
                    end
                    if (take_best) begin
                        r_best_v <= 1'b1;
                    end
                end
                mpr_pkg::ST_FETCH: r_used[r_best_idx] <= 1'b1;
                mpr_pkg::ST_EMIT: begin
                    if (oq_space) begin
                        r_rank_cnt <= r_rank_cnt + 1'b1;
                        r_scan     <= '0;
                        r_best_v   <= 1'b0;
                        if (emit_last) begin
                            r_kept <= '0;
                            r_ovf  <= 1'b0;
                        end
                    end
                end
                mpr_pkg::ST_ORPHAN: begin
                    if (oq_space) begin
                        r_kept <= '0;
                        r_ovf  <= 1'b0;
                    end
                end
                default: begin
                    r_rd_v <= 1'b0;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job.job;
        end
        if (r_state == mpr_pkg::ST_MUL) begin
            r_p_hi <= div_quo[47:16] * mpr_pkg::SCALE_101;
            r_p_lo <= div_quo[15:0] * mpr_pkg::SCALE_101;
        end
        r_rd_idx <= r_scan[IW-1:0];
        if (take_best && r_state == mpr_pkg::ST_SCAN) begin
            r_best_idx   <= r_rd_idx;
            r_best_merit <= r_merit_q;
        end
    end

    // candidate memories
    always_ff @(posedge i_clk) begin
        if (r_state == mpr_pkg::ST_STORE) begin
            id_mem[r_kept[IW-1:0]]     <= r_job.id;
            shared_mem[r_kept[IW-1:0]] <= r_job.shared;
            merit_mem[r_kept[IW-1:0]]  <= div_quo;
        end
        r_merit_q <= merit_mem[r_scan[IW-1:0]];
        r_id_q    <= id_mem[r_best_idx];
        r_sh_q    <= shared_mem[r_best_idx];
    end

    // result queue
    assign oq_pop = pop && (r_oq_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (oq_push) begin
            r_oq[r_oq_wr] <= oq_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wr  <= 1'b0;
            r_oq_rd  <= 1'b0;
            r_oq_cnt <= '0;
        end else begin
            if (oq_push) begin
                r_oq_wr <= ~r_oq_wr;
            end
            if (oq_pop) begin
                r_oq_rd <= ~r_oq_rd;
            end
            case ({oq_push, oq_pop})
                2'b10:   r_oq_cnt <= r_oq_cnt + 1'b1;
                2'b01:   r_oq_cnt <= r_oq_cnt - 1'b1;
                default: r_oq_cnt <= r_oq_cnt;
            endcase
        end
    end

    assign empty      = (r_oq_cnt == '0);
    assign o_out_word = r_oq[r_oq_rd];

endmodule

>>> sv/progenitor_merit_ranker_top.sv
// top level of the progenitor merit ranker
// Usage:
// Candidates enter as one word each on i_in_word, taken when push is high and
// full is low. A four-word queue decouples the front end from the merit
// engine. Results leave as words on o_out_word while empty is low and are
// taken when pop is high. The threshold register is written through
// i_cfg_valid / i_cfg_data; o_cfg_ready is always high.
// Flow: a kept candidate needs two passes of the shared 64-step radix-2
// divider (ratio, then merit); a dropped candidate skips the divider.
// After the word marked last_in, ranking is a selection pass per result
// over the kept candidates, bounded by one read port of the merit memory.
// Reset clears the queues, the kept count, the overflow flag and the
// threshold. When the receiver stalls, two results wait in the output queue,
// then ranking halts, then the job queue fills and full rises.
module progenitor_merit_ranker_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_data,
    input  logic               push,
    output logic               full,
    input  mpr_pkg::t_in_word  i_in_word,
    output logic               empty,
    input  logic               pop,
    output mpr_pkg::t_out_word o_out_word
);

    mpr_pkg::t_job_chan job;
    logic               job_pop;

    mpr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .full        (full),
        .i_in_word   (i_in_word),
        .o_job       (job),
        .i_job_pop   (job_pop)
    );

    mpr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (job),
        .o_job_pop  (job_pop),
        .empty      (empty),
        .pop        (pop),
        .o_out_word (o_out_word)
    );

endmodule
